[rtl/fwm_pkg.sv]
// fwm_pkg: shared constants and types of the free level watermark monitor
package fwm_pkg;

  // default widths of the item fields
  localparam int LEVEL_BITS_DEF = 24;
  localparam int TIME_BITS_DEF  = 48;
  localparam int DEPTH_BITS_DEF = 8;

  // configuration port
  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_WARN_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_PAGE_TAIL      = 2'd1;
  localparam logic [1:0] REG_MINUTE_LENGTH  = 2'd2;
  localparam logic [1:0] REG_SAMPLE_GAP     = 2'd3;

  // register reset values
  localparam logic [23:0] WARN_THRESHOLD_RST = 24'd32768;
  localparam logic [23:0] PAGE_TAIL_RST      = 24'd200000;
  localparam logic [31:0] MINUTE_LENGTH_RST  = 32'd60000000;
  localparam logic [15:0] SAMPLE_GAP_RST     = 16'd1000;

  // command codes
  localparam logic [2:0] CMD_SAMPLE       = 3'd0;
  localparam logic [2:0] CMD_PAGE_ENTER   = 3'd1;
  localparam logic [2:0] CMD_PAGE_LEAVE   = 3'd2;
  localparam logic [2:0] CMD_WINDOW_RESET = 3'd3;
  localparam logic [2:0] CMD_TAKE_WARNING = 3'd4;

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_STREAM = 2'd1;
  localparam logic [1:0] PH_PAGE   = 2'd2;

  // warning status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_HANDED  = 2'd2;
  localparam logic [1:0] ST_EARLIER = 2'd3;

  // configuration register set
  typedef struct packed {
    logic [23:0] warn_threshold;
    logic [23:0] page_tail_us;
    logic [31:0] minute_length_us;
    logic [15:0] sample_gap_us;
  } cfg_t;

endpackage

[rtl/fwm_regs.sv]
// fwm_regs: configuration registers behind the apb-style port
module fwm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwm_pkg::PADDR_BITS-1:0] paddr,
  input  logic [fwm_pkg::PDATA_BITS-1:0] pwdata,
  output logic [fwm_pkg::PDATA_BITS-1:0] prdata,
  output logic                          pready,
  output fwm_pkg::cfg_t                 cfg
);
  import fwm_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_threshold   <= WARN_THRESHOLD_RST;
      cfg.page_tail_us     <= PAGE_TAIL_RST;
      cfg.minute_length_us <= MINUTE_LENGTH_RST;
      cfg.sample_gap_us    <= SAMPLE_GAP_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WARN_THRESHOLD: cfg.warn_threshold   <= pwdata[23:0];
        REG_PAGE_TAIL:      cfg.page_tail_us     <= pwdata[23:0];
        REG_MINUTE_LENGTH:  cfg.minute_length_us <= pwdata[31:0];
        REG_SAMPLE_GAP:     cfg.sample_gap_us    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_WARN_THRESHOLD: prdata = {8'd0, cfg.warn_threshold};
      REG_PAGE_TAIL:      prdata = {8'd0, cfg.page_tail_us};
      REG_MINUTE_LENGTH:  prdata = cfg.minute_length_us;
      REG_SAMPLE_GAP:     prdata = {16'd0, cfg.sample_gap_us};
      default:            prdata = '0;
    endcase
  end

endmodule

[rtl/free_level_watermark_monitor.sv]
// free_level_watermark_monitor: top level of the free level watermark monitor
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    command, time_us, free_level, client_connected
//   out       output     out_valid / out_stall  warning, minima, minute values, minutes_done
//   cfg       input      psel/penable/pready    paddr, pwdata, prdata
//
// one item per cycle while the output is not stalled; an accepted item goes into the input
// register and then into the output register, where its result can be taken
// every item gives exactly one result item
// rst is synchronous and clears all tracking state; the first sample that passes the gap check starts the window
// a stalled output holds the item in the input register; while a result waits, one
// more item can still be taken into an empty input register
module free_level_watermark_monitor #(
  parameter int LEVEL_BITS = fwm_pkg::LEVEL_BITS_DEF,
  parameter int TIME_BITS  = fwm_pkg::TIME_BITS_DEF,
  parameter int DEPTH_BITS = fwm_pkg::DEPTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     command,
  input  logic [TIME_BITS-1:0]           time_us,
  input  logic [LEVEL_BITS-1:0]          free_level,
  input  logic                           client_connected,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     warn_status,
  output logic [LEVEL_BITS-1:0]          warn_level,
  output logic [1:0]                     warn_phase,
  output logic [LEVEL_BITS-1:0]          window_min,
  output logic [LEVEL_BITS-1:0]          idle_min,
  output logic [LEVEL_BITS-1:0]          stream_min,
  output logic [LEVEL_BITS-1:0]          page_min,
  output logic [LEVEL_BITS-1:0]          first_minute_min,
  output logic [LEVEL_BITS-1:0]          last_minute_min,
  output logic [LEVEL_BITS-1:0]          first_minute_max,
  output logic [LEVEL_BITS-1:0]          last_minute_max,
  output logic [31:0]                    minutes_done,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fwm_pkg::PADDR_BITS-1:0] paddr,
  input  logic [fwm_pkg::PDATA_BITS-1:0] pwdata,
  output logic [fwm_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);
  import fwm_pkg::*;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [DEPTH_BITS-1:0] depth_t;

  localparam level_t LEVEL_ONES = {LEVEL_BITS{1'b1}};
  localparam depth_t DEPTH_MAX  = {DEPTH_BITS{1'b1}};

  cfg_t cfg;

  // input register
  logic       s1_valid;
  logic [2:0] s1_command;
  time_t      s1_time;
  level_t     s1_free;
  logic       s1_client;
  logic       s1_load;
  logic       s1_adv;

  // tracking state
  level_t      idle_minimum, idle_minimum_next;
  level_t      stream_minimum, stream_minimum_next;
  level_t      page_minimum, page_minimum_next;
  level_t      window_minimum, window_minimum_next;
  level_t      minute_min_now, minute_min_now_next;
  level_t      minute_max_now, minute_max_now_next;
  level_t      minute_min_first, minute_min_first_next;
  level_t      minute_min_last, minute_min_last_next;
  level_t      minute_max_first, minute_max_first_next;
  level_t      minute_max_last, minute_max_last_next;
  logic [31:0] minute_count, minute_count_next;
  time_t       minute_start, minute_start_next;
  time_t       last_sample, last_sample_next;
  depth_t      page_depth, page_depth_next;
  time_t       page_left, page_left_next;
  logic        page_left_seen, page_left_seen_next;
  logic        warning_pending, warning_pending_next;
  logic        warning_given, warning_given_next;
  level_t      warning_level, warning_level_next;
  logic [1:0]  warning_phase, warning_phase_next;
  logic        window_reset_pending, window_reset_pending_next;
  logic [1:0]  status_next;

  // sample datapath
  time_t       gap_diff;
  logic        sample_ok;
  time_t       tail_diff;
  logic        in_tail;
  logic [1:0]  phase;
  level_t      mmin_upd;
  level_t      mmax_upd;
  level_t      first_min_base, first_max_base, last_min_base, last_max_base;
  logic [31:0] count_base;
  time_t       start_base;
  time_t       minute_diff;
  logic        roll;
  logic        below_warn;

  fwm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign s1_load  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (s1_load) begin
      s1_command <= command;
      s1_time    <= time_us;
      s1_free    <= free_level;
      s1_client  <= client_connected;
    end
  end

  // sample checks that stand beside the state update
  always_comb begin
    gap_diff    = s1_time - last_sample;
    sample_ok   = (s1_time >= last_sample) && (gap_diff >= time_t'(cfg.sample_gap_us));
    tail_diff   = s1_time - page_left;
    in_tail     = page_left_seen && (s1_time >= page_left)
                  && (tail_diff < time_t'(cfg.page_tail_us));
    below_warn  = 32'(s1_free) < 32'(cfg.warn_threshold);
    if (page_depth != '0 || in_tail) begin
      phase = PH_PAGE;
    end else if (s1_client) begin
      phase = PH_STREAM;
    end else begin
      phase = PH_IDLE;
    end

    // a pending window reset starts the minute at the sample and clears the minute history
    if (window_reset_pending) begin
      mmin_upd       = s1_free;
      mmax_upd       = s1_free;
      first_min_base = LEVEL_ONES;
      first_max_base = LEVEL_ONES;
      last_min_base  = LEVEL_ONES;
      last_max_base  = LEVEL_ONES;
      count_base     = '0;
      start_base     = s1_time;
    end else begin
      mmin_upd       = (s1_free < minute_min_now) ? s1_free : minute_min_now;
      mmax_upd       = (s1_free > minute_max_now) ? s1_free : minute_max_now;
      first_min_base = minute_min_first;
      first_max_base = minute_max_first;
      last_min_base  = minute_min_last;
      last_max_base  = minute_max_last;
      count_base     = minute_count;
      start_base     = minute_start;
    end
    minute_diff = s1_time - start_base;
    roll        = (s1_time >= start_base)
                  && (minute_diff >= time_t'(cfg.minute_length_us));
  end

  // next state for the item in the input register
  always_comb begin
    idle_minimum_next         = idle_minimum;
    stream_minimum_next       = stream_minimum;
    page_minimum_next         = page_minimum;
    window_minimum_next       = window_minimum;
    minute_min_now_next       = minute_min_now;
    minute_max_now_next       = minute_max_now;
    minute_min_first_next     = minute_min_first;
    minute_min_last_next      = minute_min_last;
    minute_max_first_next     = minute_max_first;
    minute_max_last_next      = minute_max_last;
    minute_count_next         = minute_count;
    minute_start_next         = minute_start;
    last_sample_next          = last_sample;
    page_depth_next           = page_depth;
    page_left_next            = page_left;
    page_left_seen_next       = page_left_seen;
    warning_pending_next      = warning_pending;
    warning_given_next        = warning_given;
    warning_level_next        = warning_level;
    warning_phase_next        = warning_phase;
    window_reset_pending_next = window_reset_pending;
    status_next               = ST_NONE;

    unique case (s1_command)
      CMD_SAMPLE: begin
        if (sample_ok) begin
          last_sample_next          = s1_time;
          window_reset_pending_next = 1'b0;
          // phase minima
          if (phase == PH_IDLE && s1_free < idle_minimum) begin
            idle_minimum_next = s1_free;
          end
          if (phase == PH_STREAM && s1_free < stream_minimum) begin
            stream_minimum_next = s1_free;
          end
          if (phase == PH_PAGE && s1_free < page_minimum) begin
            page_minimum_next = s1_free;
          end
          // window minimum
          if (window_reset_pending || s1_free < window_minimum) begin
            window_minimum_next = s1_free;
          end
          // minute tracking and rollover
          minute_min_first_next = first_min_base;
          minute_max_first_next = first_max_base;
          minute_min_last_next  = last_min_base;
          minute_max_last_next  = last_max_base;
          minute_count_next     = count_base;
          minute_start_next     = start_base;
          minute_min_now_next   = mmin_upd;
          minute_max_now_next   = mmax_upd;
          if (roll) begin
            minute_min_last_next = mmin_upd;
            minute_max_last_next = mmax_upd;
            if (count_base == '0) begin
              minute_min_first_next = mmin_upd;
              minute_max_first_next = mmax_upd;
            end
            if (count_base != 32'hFFFF_FFFF) begin
              minute_count_next = count_base + 32'd1;
            end
            minute_min_now_next = s1_free;
            minute_max_now_next = s1_free;
            minute_start_next   = s1_time;
          end
          // one-shot warning capture
          if (!warning_given && !warning_pending && below_warn) begin
            warning_level_next   = s1_free;
            warning_phase_next   = phase;
            warning_pending_next = 1'b1;
          end
        end
      end
      CMD_PAGE_ENTER: begin
        if (page_depth != DEPTH_MAX) begin
          page_depth_next = page_depth + depth_t'(1);
        end
      end
      CMD_PAGE_LEAVE: begin
        if (page_depth != '0) begin
          page_depth_next = page_depth - depth_t'(1);
        end
        page_left_next      = s1_time;
        page_left_seen_next = 1'b1;
      end
      CMD_WINDOW_RESET: begin
        window_reset_pending_next = 1'b1;
      end
      CMD_TAKE_WARNING: begin
        if (warning_pending) begin
          warning_given_next   = 1'b1;
          warning_pending_next = 1'b0;
        end
      end
      default: ;
    endcase

    // warning status after the item
    if (s1_command == CMD_TAKE_WARNING && warning_pending) begin
      status_next = ST_HANDED;
    end else if (warning_pending_next) begin
      status_next = ST_PENDING;
    end else if (warning_given_next) begin
      status_next = ST_EARLIER;
    end else begin
      status_next = ST_NONE;
    end
  end

  // tracking state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_minimum         <= LEVEL_ONES;
      stream_minimum       <= LEVEL_ONES;
      page_minimum         <= LEVEL_ONES;
      window_minimum       <= LEVEL_ONES;
      minute_min_now       <= LEVEL_ONES;
      minute_max_now       <= '0;
      minute_min_first     <= LEVEL_ONES;
      minute_min_last      <= LEVEL_ONES;
      minute_max_first     <= LEVEL_ONES;
      minute_max_last      <= LEVEL_ONES;
      minute_count         <= '0;
      minute_start         <= '0;
      last_sample          <= '0;
      page_depth           <= '0;
      page_left            <= '0;
      page_left_seen       <= 1'b0;
      warning_pending      <= 1'b0;
      warning_given        <= 1'b0;
      warning_level        <= '0;
      warning_phase        <= PH_IDLE;
      window_reset_pending <= 1'b1;
    end else if (s1_adv) begin
      idle_minimum         <= idle_minimum_next;
      stream_minimum       <= stream_minimum_next;
      page_minimum         <= page_minimum_next;
      window_minimum       <= window_minimum_next;
      minute_min_now       <= minute_min_now_next;
      minute_max_now       <= minute_max_now_next;
      minute_min_first     <= minute_min_first_next;
      minute_min_last      <= minute_min_last_next;
      minute_max_first     <= minute_max_first_next;
      minute_max_last      <= minute_max_last_next;
      minute_count         <= minute_count_next;
      minute_start         <= minute_start_next;
      last_sample          <= last_sample_next;
      page_depth           <= page_depth_next;
      page_left            <= page_left_next;
      page_left_seen       <= page_left_seen_next;
      warning_pending      <= warning_pending_next;
      warning_given        <= warning_given_next;
      warning_level        <= warning_level_next;
      warning_phase        <= warning_phase_next;
      window_reset_pending <= window_reset_pending_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_adv) begin
      warn_status      <= status_next;
      warn_level       <= warning_level_next;
      warn_phase       <= warning_phase_next;
      window_min       <= window_minimum_next;
      idle_min         <= idle_minimum_next;
      stream_min       <= stream_minimum_next;
      page_min         <= page_minimum_next;
      first_minute_min <= minute_min_first_next;
      last_minute_min  <= minute_min_last_next;
      first_minute_max <= minute_max_first_next;
      last_minute_max  <= minute_max_last_next;
      minutes_done     <= minute_count_next;
    end
  end

  // the warning is never pending and handed over at once
  a_warn_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(warning_pending && warning_given))
    else $error("warning pending and given together");

  // taking a pending warning hands it over
  a_warn_take: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_command == CMD_TAKE_WARNING && warning_pending
    |=> warning_given && !warning_pending && out_valid && warn_status == ST_HANDED)
    else $error("pending warning not handed over");

  // before the first rollover the first-minute values read as never seen
  a_first_minute: assert property (@(posedge clk) disable iff (rst)
    minute_count == '0 |-> minute_min_first == LEVEL_ONES && minute_max_first == LEVEL_ONES)
    else $error("first minute set without a rollover");

  // the input side only waits behind a full input register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

[test/testbench.sv]
// testbench for the free level watermark monitor: predicted report per item, apb setup
`timescale 1ns / 1ps

module testbench;
  import fwm_pkg::*;

  localparam logic [23:0] LEVEL_NONE  = 24'hFFFFFF;
  localparam logic [23:0] LEVEL_TOP   = 24'd16777214;
  localparam logic [7:0]  DEPTH_TOP   = 8'hFF;
  localparam logic [31:0] MINUTES_TOP = 32'hFFFFFFFF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0]  cmd;
    logic [47:0] stamp;
    logic [23:0] level;
    logic        client;
  } event_t;

  typedef struct {
    logic [1:0]  status;
    logic [23:0] level;
    logic [1:0]  phase;
    logic [23:0] window;
    logic [23:0] idle;
    logic [23:0] stream;
    logic [23:0] page;
    logic [23:0] first_min;
    logic [23:0] last_min;
    logic [23:0] first_max;
    logic [23:0] last_max;
    logic [31:0] minutes;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = CMD_SAMPLE;
  logic [47:0] time_us = '0;
  logic [23:0] free_level = '0;
  logic        client_connected = 1'b0;

  // output channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  warn_status;
  logic [23:0] warn_level;
  logic [1:0]  warn_phase;
  logic [23:0] window_min;
  logic [23:0] idle_min;
  logic [23:0] stream_min;
  logic [23:0] page_min;
  logic [23:0] first_minute_min;
  logic [23:0] last_minute_min;
  logic [23:0] first_minute_max;
  logic [23:0] last_minute_max;
  logic [31:0] minutes_done;

  // configuration port
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  free_level_watermark_monitor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .time_us(time_us), .free_level(free_level),
    .client_connected(client_connected),
    .out_valid(out_valid), .out_stall(out_stall),
    .warn_status(warn_status), .warn_level(warn_level), .warn_phase(warn_phase),
    .window_min(window_min), .idle_min(idle_min), .stream_min(stream_min),
    .page_min(page_min), .first_minute_min(first_minute_min),
    .last_minute_min(last_minute_min), .first_minute_max(first_minute_max),
    .last_minute_max(last_minute_max), .minutes_done(minutes_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // run bookkeeping
  event_t      pending_items[$];
  report_t     due_reports[$];
  logic        in_fire = 1'b0;
  logic        no_gaps = 1'b0;
  bit          failed = 1'b0;
  int unsigned cycles = 0;
  logic [47:0] gen_now = '0;

  // predictor copy of the registers
  logic [23:0] cfg_warn   = WARN_THRESHOLD_RST;
  logic [23:0] cfg_tail   = PAGE_TAIL_RST;
  logic [31:0] cfg_minute = MINUTE_LENGTH_RST;
  logic [15:0] cfg_gap    = SAMPLE_GAP_RST;

  // predictor copy of the tracking state
  logic [23:0] phase_floor [0:2] = '{LEVEL_NONE, LEVEL_NONE, LEVEL_NONE};
  logic [23:0] window_floor = LEVEL_NONE;
  logic [23:0] minute_floor = LEVEL_NONE;
  logic [23:0] minute_peak = '0;
  logic [23:0] first_floor = LEVEL_NONE;
  logic [23:0] last_floor = LEVEL_NONE;
  logic [23:0] first_peak = LEVEL_NONE;
  logic [23:0] last_peak = LEVEL_NONE;
  logic [31:0] minutes_seen = '0;
  logic [47:0] minute_opened = '0;
  logic [47:0] last_taken = '0;
  logic [7:0]  page_depth = '0;
  logic [47:0] page_left_t = '0;
  logic        page_left_seen = 1'b0;
  logic        alarm_pending = 1'b0;
  logic        alarm_given = 1'b0;
  logic [23:0] alarm_level = '0;
  logic [1:0]  alarm_phase = PH_IDLE;
  logic        restart_pending = 1'b1;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // update the watermark state for one item and form its report
  function automatic report_t step_watermarks(logic [2:0] cmd, logic [47:0] t,
                                              logic [23:0] lvl, logic client);
    report_t r;
    logic handed;
    logic [1:0] ph;
    handed = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        if (t >= last_taken && (t - last_taken) >= {32'd0, cfg_gap}) begin
          last_taken = t;
          // a pending window reset takes effect on this sample
          if (restart_pending) begin
            restart_pending = 1'b0;
            window_floor = lvl;
            first_floor = LEVEL_NONE;
            last_floor = LEVEL_NONE;
            first_peak = LEVEL_NONE;
            last_peak = LEVEL_NONE;
            minute_floor = lvl;
            minute_peak = lvl;
            minutes_seen = '0;
            minute_opened = t;
          end
          // phase: page depth, then page tail, then client
          if (page_depth != 0) begin
            ph = PH_PAGE;
          end else if (page_left_seen && t >= page_left_t &&
                       (t - page_left_t) < {24'd0, cfg_tail}) begin
            ph = PH_PAGE;
          end else begin
            ph = client ? PH_STREAM : PH_IDLE;
          end
          if (lvl < phase_floor[ph]) phase_floor[ph] = lvl;
          if (lvl < window_floor) window_floor = lvl;
          if (lvl < minute_floor) minute_floor = lvl;
          if (lvl > minute_peak) minute_peak = lvl;
          // minute rollover
          if (t >= minute_opened && (t - minute_opened) >= {16'd0, cfg_minute}) begin
            last_floor = minute_floor;
            last_peak = minute_peak;
            if (minutes_seen == 0) begin
              first_floor = minute_floor;
              first_peak = minute_peak;
            end
            if (minutes_seen != MINUTES_TOP) minutes_seen = minutes_seen + 32'd1;
            minute_floor = lvl;
            minute_peak = lvl;
            minute_opened = t;
          end
          // one-shot low level warning
          if (!alarm_given && !alarm_pending && lvl < cfg_warn) begin
            alarm_level = lvl;
            alarm_phase = ph;
            alarm_pending = 1'b1;
          end
        end
      end
      CMD_PAGE_ENTER: begin
        if (page_depth != DEPTH_TOP) page_depth = page_depth + 8'd1;
      end
      CMD_PAGE_LEAVE: begin
        if (page_depth != 0) page_depth = page_depth - 8'd1;
        page_left_t = t;
        page_left_seen = 1'b1;
      end
      CMD_WINDOW_RESET: begin
        restart_pending = 1'b1;
      end
      CMD_TAKE_WARNING: begin
        if (alarm_pending) begin
          alarm_given = 1'b1;
          alarm_pending = 1'b0;
          handed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (handed) r.status = ST_HANDED;
    else if (alarm_pending) r.status = ST_PENDING;
    else if (alarm_given) r.status = ST_EARLIER;
    else r.status = ST_NONE;
    r.level = alarm_level;
    r.phase = alarm_phase;
    r.window = window_floor;
    r.idle = phase_floor[PH_IDLE];
    r.stream = phase_floor[PH_STREAM];
    r.page = phase_floor[PH_PAGE];
    r.first_min = first_floor;
    r.last_min = last_floor;
    r.first_max = first_peak;
    r.last_max = last_peak;
    r.minutes = minutes_seen;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      failed = 1'b1;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // level mix: full range, low range, around the threshold, extremes, upper half
  function automatic logic [23:0] pick_level();
    int roll;
    int near;
    roll = $urandom_range(99);
    if (roll < 30) return 24'($urandom_range(LEVEL_TOP));
    if (roll < 65) return 24'($urandom_range(100000));
    if (roll < 80) begin
      near = int'(cfg_warn) + int'($urandom_range(2)) - 1;
      if (near < 0) near = 0;
      if (near > int'(LEVEL_TOP)) near = int'(LEVEL_TOP);
      return near[23:0];
    end
    if (roll < 90) return $urandom_range(1) ? LEVEL_TOP : 24'd0;
    return 24'($urandom_range(LEVEL_TOP)) | 24'h800000;
  endfunction

  task automatic queue_sample(input logic [47:0] t, input logic [23:0] lvl,
                              input logic client);
    event_t e;
    e.cmd = CMD_SAMPLE;
    e.stamp = t;
    e.level = lvl;
    e.client = client;
    pending_items.push_back(e);
  endtask

  // non-sample commands carry random level and client bits
  task automatic queue_event(input logic [2:0] cmd, input logic [47:0] t);
    event_t e;
    e.cmd = cmd;
    e.stamp = t;
    e.level = 24'($urandom_range(LEVEL_TOP));
    e.client = 1'($urandom_range(1));
    pending_items.push_back(e);
  endtask

  // mostly forward-moving traffic, a few stale samples
  task automatic queue_random(input int count);
    logic [47:0] step;
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        step = 48'($urandom_range(5000));
        queue_sample((gen_now >= step) ? gen_now - step : 48'd0, pick_level(),
                     1'($urandom_range(1)));
      end else begin
        roll = $urandom_range(99);
        if (roll < 55) step = 48'(cfg_gap) + 48'($urandom_range(2 * cfg_gap + 50));
        else if (roll < 75) step = 48'($urandom_range(cfg_tail + 100));
        else if (roll < 85) step = 48'($urandom_range(cfg_minute));
        else if (roll < 95) begin
          case ($urandom_range(3))
            0: step = 48'(cfg_gap);
            1: step = 48'(cfg_tail);
            2: step = 48'(cfg_minute);
            default: step = 48'(cfg_minute) - 48'd1;
          endcase
        end else step = '0;
        gen_now = gen_now + step;
        roll = $urandom_range(99);
        if (roll < 60) queue_sample(gen_now, pick_level(), 1'($urandom_range(1)));
        else if (roll < 70) queue_event(CMD_PAGE_ENTER, gen_now);
        else if (roll < 80) queue_event(CMD_PAGE_LEAVE, gen_now);
        else if (roll < 88) queue_event(CMD_WINDOW_RESET, gen_now);
        else queue_event(CMD_TAKE_WARNING, gen_now);
      end
    end
  endtask

  // apb write, then read the register back
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] held;
    case (idx)
      REG_WARN_THRESHOLD: begin
        cfg_warn = value[23:0];
        held = {8'd0, value[23:0]};
      end
      REG_PAGE_TAIL: begin
        cfg_tail = value[23:0];
        held = {8'd0, value[23:0]};
      end
      REG_MINUTE_LENGTH: begin
        cfg_minute = value;
        held = value;
      end
      REG_SAMPLE_GAP: begin
        cfg_gap = value[15:0];
        held = {16'd0, value[15:0]};
      end
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("register readback", 48'(held), 48'(prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every queued item is through and reported; the second pass
  // covers an item popped by the driver in the same cycle as the first check
  task automatic settle();
    repeat (2) begin
      while (pending_items.size() != 0 || in_valid || due_reports.size() != 0)
        @(negedge clk);
      repeat (4) @(negedge clk);
    end
  endtask

  // input driver
  always @(negedge clk) begin : feed
    event_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_items.size() != 0 && (no_gaps || $urandom_range(99) >= 11)) begin
        e = pending_items.pop_front();
        command <= e.cmd;
        time_us <= e.stamp;
        free_level <= e.level;
        client_connected <= e.client;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 11);
  end

  // predict accepted items, check delivered reports
  always @(posedge clk) begin : watch
    report_t want;
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire)
      due_reports.push_back(step_watermarks(command, time_us, free_level, client_connected));
    if (!rst && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        failed = 1'b1;
        $display("%0t: report with no item waiting", $time);
      end else begin
        want = due_reports.pop_front();
        check_field("warn_status", 48'(want.status), 48'(warn_status));
        check_field("warn_level", 48'(want.level), 48'(warn_level));
        check_field("warn_phase", 48'(want.phase), 48'(warn_phase));
        check_field("window_min", 48'(want.window), 48'(window_min));
        check_field("idle_min", 48'(want.idle), 48'(idle_min));
        check_field("stream_min", 48'(want.stream), 48'(stream_min));
        check_field("page_min", 48'(want.page), 48'(page_min));
        check_field("first_minute_min", 48'(want.first_min), 48'(first_minute_min));
        check_field("last_minute_min", 48'(want.last_min), 48'(last_minute_min));
        check_field("first_minute_max", 48'(want.first_max), 48'(first_minute_max));
        check_field("last_minute_max", 48'(want.last_max), 48'(last_minute_max));
        check_field("minutes_done", 48'(want.minutes), 48'(minutes_done));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("free_level_watermark_monitor test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset settings
    queue_event(CMD_TAKE_WARNING, 48'd0);        // nothing pending yet
    queue_sample(48'd999, 24'd50000, 1'b0);      // inside the gap after reset
    queue_sample(48'd1000, 24'd900000, 1'b0);    // starts the window
    queue_sample(48'd1999, 24'd40000, 1'b1);     // too close
    queue_sample(48'd2000, LEVEL_TOP, 1'b1);
    queue_event(CMD_PAGE_ENTER, 48'd2500);
    queue_event(CMD_PAGE_ENTER, 48'd2600);
    queue_sample(48'd3000, 24'd32768, 1'b1);     // page, at the threshold
    queue_event(CMD_PAGE_LEAVE, 48'd3500);
    queue_event(CMD_PAGE_LEAVE, 48'd4000);
    queue_event(CMD_PAGE_LEAVE, 48'd4100);       // leave at zero depth
    queue_sample(48'd204099, 24'd60000, 1'b0);   // last tick of the page tail
    queue_sample(48'd205100, 24'd70000, 1'b1);   // tail over
    queue_sample(48'd100, 24'd33000, 1'b0);      // time went backwards
    queue_sample(48'd60_001_000, 24'd500000, 1'b0);  // first minute closes
    queue_sample(48'd120_001_000, 24'd600000, 1'b1); // second minute closes
    queue_event(CMD_WINDOW_RESET, 48'd120_002_000);
    queue_event(CMD_PAGE_ENTER, 48'hFFFF_FFFF_FFFF);
    queue_event(CMD_PAGE_LEAVE, 48'hFFFF_FFFF_FFFF); // leave time far ahead
    queue_sample(48'd120_003_000, 24'd45000, 1'b1);  // window restarts here
    queue_event(CMD_TAKE_WARNING, 48'd120_003_500);
    queue_sample(48'd180_003_000, LEVEL_TOP, 1'b0);
    gen_now = 48'd180_003_000;
    settle();

    // low extremes: no warning possible, rollover at nearly every sample
    write_reg(REG_WARN_THRESHOLD, 32'd0);
    write_reg(REG_PAGE_TAIL, 32'd1000);
    write_reg(REG_MINUTE_LENGTH, 32'd1);
    write_reg(REG_SAMPLE_GAP, 32'd0);
    queue_random(100);
    settle();

    // high extremes: warning raised on the first kept sample
    write_reg(REG_WARN_THRESHOLD, 32'h00FF_FFFF);
    write_reg(REG_PAGE_TAIL, 32'h00FF_FFFF);
    write_reg(REG_MINUTE_LENGTH, 32'hFFFF_FFFF);
    write_reg(REG_SAMPLE_GAP, 32'h0000_FFFF);
    queue_random(100);
    settle();

    // page depth ceiling with no tail
    write_reg(REG_WARN_THRESHOLD, 32'd16000);
    write_reg(REG_PAGE_TAIL, 32'd0);
    write_reg(REG_MINUTE_LENGTH, 32'd5_000_000);
    write_reg(REG_SAMPLE_GAP, 32'd200);
    for (int k = 0; k < 260; k++) queue_event(CMD_PAGE_ENTER, gen_now + 48'(k));
    gen_now = gen_now + 48'd1000;
    queue_sample(gen_now, pick_level(), 1'b0);
    for (int k = 0; k < 255; k++) queue_event(CMD_PAGE_LEAVE, gen_now + 48'(k));
    gen_now = gen_now + 48'd1000;
    queue_sample(gen_now, pick_level(), 1'b1);   // depth back at zero
    queue_event(CMD_PAGE_LEAVE, gen_now + 48'd1);
    gen_now = gen_now + 48'd1000;
    queue_sample(gen_now, pick_level(), 1'b0);
    queue_random(60);
    settle();

    // full rate on both sides
    write_reg(REG_WARN_THRESHOLD, 32'd500000);
    write_reg(REG_PAGE_TAIL, 32'd300000);
    write_reg(REG_MINUTE_LENGTH, 32'd2_000_000);
    write_reg(REG_SAMPLE_GAP, 32'd500);
    no_gaps = 1'b1;
    queue_random(100);
    settle();
    no_gaps = 1'b0;

    // reset settings again, then times near the top of the range
    write_reg(REG_WARN_THRESHOLD, 32'd32768);
    write_reg(REG_PAGE_TAIL, 32'd200000);
    write_reg(REG_MINUTE_LENGTH, 32'd60_000_000);
    write_reg(REG_SAMPLE_GAP, 32'd1000);
    queue_random(50);
    gen_now = 48'hFFFF_F000_0000;
    queue_random(30);
    settle();

    if (failed) begin
      $display("free_level_watermark_monitor test failed");
    end else begin
      $display("free_level_watermark_monitor test passed");
    end
    $finish;
  end

endmodule

[free_level_watermark_monitor.f]
rtl/fwm_pkg.sv
rtl/fwm_regs.sv
rtl/free_level_watermark_monitor.sv
test/testbench.sv
